@@ hw/rtl/cube_event_midi_note_manager_macros.svh @@
// Assertion macros shared by the cube event MIDI note manager.
`ifndef CUBE_EVENT_MIDI_NOTE_MANAGER_MACROS_SVH
`define CUBE_EVENT_MIDI_NOTE_MANAGER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define CEMNM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CEMNM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/cemnm_pkg.sv @@
// Shared types, constants and pitch tables of the cube note manager.
`timescale 1ns / 1ps
package cemnm_pkg;

	// Register indexes of the configuration port
	localparam logic [1:0] REG_STRIKE_LIMIT = 2'd0;
	localparam logic [1:0] REG_STRIKE_HOLD  = 2'd1;
	localparam logic [1:0] REG_BASE_NOTE    = 2'd2;
	localparam logic [1:0] REG_DRUM_MODE    = 2'd3;

	// Cube event codes
	localparam logic [2:0] CODE_MUTE   = 3'd0;
	localparam logic [2:0] CODE_MCHG   = 3'd7;
	localparam logic [2:0] LAST_NOTE   = 3'd6;

	localparam logic [2:0] MAX_OUT     = 3'd7;
	localparam logic [7:0] STATUS_ON   = 8'h90;
	localparam logic [7:0] STATUS_OFF  = 8'h80;
	localparam logic [6:0] VELOCITY    = 7'd100;

	// Command queue depth (power of two)
	localparam int FIFO_DEPTH = 4;

	// One message request from the front sequencer; mode is a five-bit field (0..31)
	typedef struct packed {
		logic       on;
		logic [4:0] mode;
		logic [2:0] note;
		logic       last;
	} cmd_t;

	// Front status seen by the top level
	typedef struct packed {
		logic idle;
		logic pend;
	} front_stat_t;

	function automatic logic [2:0] note_slot(input logic [2:0] n);
		logic [2:0] j;
		j = 3'd0;
		if (n >= 3'd1 && n <= LAST_NOTE) j = n - 3'd1;
		return j;
	endfunction

	function automatic logic [6:0] drum_note(input logic [2:0] j);
		logic [6:0] r;
		case (j)
			3'd0: r = 7'd36;
			3'd1: r = 7'd40;
			3'd2: r = 7'd42;
			3'd3: r = 7'd47;
			3'd4: r = 7'd48;
			3'd5: r = 7'd49;
			default: r = 7'd36;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] interval(input logic [2:0] j);
		logic [3:0] r;
		case (j)
			3'd0: r = 4'd0;
			3'd1: r = 4'd3;
			3'd2: r = 4'd5;
			3'd3: r = 4'd7;
			3'd4: r = 4'd10;
			3'd5: r = 4'd12;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	// Octave shift of a mode in semitones; zero outside modes one to eight
	function automatic logic signed [8:0] octave_shift(input logic [4:0] m);
		logic signed [8:0] r;
		case (m)
			5'd2, 5'd4, 5'd6: r = -9'sd12;
			5'd5, 5'd7:       r = -9'sd24;
			default:          r = 9'sd0;
		endcase
		return r;
	endfunction

	// Pitch of note n in mode m, saturated to 0..127; in the drum mode the pitch comes from the drum table
	function automatic logic [6:0] pitch_of(input logic [4:0] m, input logic [2:0] n,
			input logic [6:0] base, input logic [3:0] drum);
		logic [2:0]        j;
		logic signed [8:0] p;
		logic [6:0]        r;
		j = note_slot(n);
		p = $signed({2'b00, base}) + $signed({5'b00000, interval(j)}) + octave_shift(m);
		if (m == {1'b0, drum}) r = drum_note(j);
		else if (p < 0) r = 7'd0;
		else if (p > 9'sd127) r = 7'd127;
		else r = p[6:0];
		return r;
	endfunction

endpackage

@@ hw/rtl/cemnm_cmd_fifo.sv @@
// Short command queue between the front sequencer and the message unit.
`timescale 1ns / 1ps
module cemnm_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cemnm_pkg::cmd_t   push_cmd,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output cemnm_pkg::cmd_t   pop_cmd
);
	localparam int PW = $clog2(cemnm_pkg::FIFO_DEPTH);

	cemnm_pkg::cmd_t mem_q [cemnm_pkg::FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     count_q;

	assign full    = (count_q == (PW+1)'(cemnm_pkg::FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign pop_cmd = mem_q[rd_ptr_q];

	// Store a word at the write pointer
	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_ptr_q] <= push_cmd;
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && !full) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop && !empty) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push && !full, pop && !empty})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule

@@ hw/rtl/cemnm_front.sv @@
// Front sequencer: accepts items, owns the cube table, queues message commands.
`timescale 1ns / 1ps
module cemnm_front #(
	parameter int CUBES = 6,
	parameter int MODES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [47:0]            s_tdata,
	input  logic                   s_tuser,
	input  logic [3:0]             strike_limit,
	input  logic [15:0]            strike_hold,
	output logic                   push,
	output cemnm_pkg::cmd_t        push_cmd,
	input  logic                   full,
	output cemnm_pkg::front_stat_t stat
);
	localparam int CW = (CUBES > 1) ? $clog2(CUBES) : 1;
	localparam logic [4:0]    CUBES5  = 5'(CUBES);
	localparam logic [CW-1:0] LAST_IX = CW'(CUBES - 1);
	localparam logic [4:0]    MODES5  = 5'(MODES);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_EVT1  = 3'd1;
	localparam logic [2:0] ST_EVT2  = 3'd2;
	localparam logic [2:0] ST_MCHG  = 3'd3;
	localparam logic [2:0] ST_PREP  = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;
	localparam logic [2:0] ST_FLUSH = 3'd6;

	logic [2:0]      st_q;
	logic [CW-1:0]   idx_q;
	logic [2:0]      k_q;
	logic [2:0]      cnt_q;
	logic            pend_q;
	cemnm_pkg::cmd_t pend_cmd_q;

	// Latched item
	logic [2:0]  code_q;
	logic [3:0]  vm_q;
	logic [31:0] now_q;

	// Cube table
	logic [2:0]       note_q  [CUBES];
	logic [3:0]       mode_q  [CUBES];
	logic [31:0]      start_q [CUBES];
	logic [CUBES-1:0] snd_q;
	logic [CUBES-1:0] old_q;
	logic [CUBES-1:0] young_q;

	logic [2:0]       in_code;
	logic [3:0]       in_vm;
	logic [2:0]       in_cid;
	logic             cid_ok;
	logic [CW-1:0]    in_idx;
	logic             accept;

	logic [2:0]       cur_note;
	logic [3:0]       cur_mode;
	logic             cur_snd;
	logic [CUBES-1:0] match;
	logic             shared;
	logic             held;
	logic [4:0]       pm;
	logic [31:0]      age;
	logic             expired;
	logic             gen;
	cemnm_pkg::cmd_t  gen_cmd;
	logic             want;
	logic             go;

	assign in_code = s_tdata[2:0];
	assign in_vm   = s_tdata[6:3];
	assign in_cid  = s_tdata[9:7];
	assign cid_ok  = (in_cid != 3'd0) && ({2'b00, in_cid} <= CUBES5);
	assign in_idx  = CW'({2'b00, in_cid} - 5'd1);

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Look at the current cube and compare it with all others
	assign cur_note = note_q[idx_q];
	assign cur_mode = mode_q[idx_q];
	assign cur_snd  = snd_q[idx_q];

	always_comb begin
		for (int i = 0; i < CUBES; i++) begin
			match[i] = snd_q[i] && (mode_q[i] == cur_mode) && (note_q[i] == cur_note)
				&& (CW'(i) != idx_q);
		end
	end

	assign shared  = |match;
	assign held    = |(match & young_q);
	assign pm      = (vm_q <= 4'd1) ? MODES5 : ({1'b0, vm_q} - 5'd1);
	assign age     = now_q - start_q[idx_q];
	assign expired = cur_snd && (cur_mode <= strike_limit) && old_q[idx_q];

	// Build the message this step asks for
	always_comb begin
		gen          = 1'b0;
		gen_cmd.on   = 1'b0;
		gen_cmd.mode = {1'b0, vm_q};
		gen_cmd.note = cur_note;
		gen_cmd.last = 1'b0;
		case (st_q)
			ST_EVT1: begin
				if (code_q == cemnm_pkg::CODE_MUTE) begin
					gen = !shared && (cur_note != 3'd0);
				end else if (code_q == cemnm_pkg::CODE_MCHG) begin
					gen          = !shared && (cur_note != 3'd0);
					gen_cmd.mode = pm;
				end else begin
					gen = cur_snd && (cur_note != 3'd0);
				end
			end
			ST_EVT2: begin
				gen          = 1'b1;
				gen_cmd.on   = 1'b1;
				gen_cmd.note = code_q;
			end
			ST_MCHG: begin
				gen          = 1'b1;
				gen_cmd.mode = pm;
				gen_cmd.note = k_q;
			end
			ST_SCAN: begin
				gen          = expired && !held && (cnt_q != cemnm_pkg::MAX_OUT);
				gen_cmd.mode = {1'b0, cur_mode};
			end
			default: gen = 1'b0;
		endcase
	end

	// A held command goes out when the next one arrives, or marked last at the end
	always_comb begin
		want          = pend_q && (gen || (st_q == ST_FLUSH));
		push          = want && !full;
		push_cmd      = pend_cmd_q;
		push_cmd.last = (st_q == ST_FLUSH);
	end

	assign go = !want || !full;

	assign stat.idle = (st_q == ST_IDLE);
	assign stat.pend = pend_q;

	// Latch the item payload
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= in_code;
			vm_q   <= in_vm;
			now_q  <= s_tdata[41:10];
		end
	end

	// Sequencer and cube table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			idx_q      <= '0;
			k_q        <= 3'd1;
			cnt_q      <= '0;
			pend_q     <= 1'b0;
			pend_cmd_q <= '0;
			snd_q      <= '0;
			old_q      <= '0;
			young_q    <= '0;
			for (int i = 0; i < CUBES; i++) begin
				note_q[i]  <= 3'd0;
				mode_q[i]  <= 4'd1;
				start_q[i] <= 32'd0;
			end
		end else begin
			if (go && gen) begin
				pend_q     <= 1'b1;
				pend_cmd_q <= gen_cmd;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						k_q   <= 3'd1;
						if (s_tuser) begin
							idx_q <= '0;
							st_q  <= ST_PREP;
						end else if (cid_ok) begin
							idx_q <= in_idx;
							st_q  <= ST_EVT1;
						end else begin
							st_q <= ST_FLUSH;
						end
					end
				end
				ST_EVT1: begin
					if (go) begin
						if (code_q == cemnm_pkg::CODE_MUTE) begin
							snd_q[idx_q] <= 1'b0;
							st_q         <= ST_FLUSH;
						end else if (code_q == cemnm_pkg::CODE_MCHG) begin
							snd_q[idx_q] <= 1'b0;
							st_q         <= ST_MCHG;
						end else begin
							st_q <= ST_EVT2;
						end
					end
				end
				ST_EVT2: begin
					if (go) begin
						note_q[idx_q] <= code_q;
						snd_q[idx_q]  <= 1'b1;
						if (vm_q <= strike_limit) start_q[idx_q] <= now_q;
						st_q <= ST_FLUSH;
					end
				end
				ST_MCHG: begin
					if (go) begin
						k_q <= k_q + 3'd1;
						if (k_q == cemnm_pkg::LAST_NOTE) begin
							mode_q[idx_q] <= vm_q;
							st_q          <= ST_FLUSH;
						end
					end
				end
				ST_PREP: begin
					// Sort each cube's age against the hold time, one cube a cycle
					old_q[idx_q]   <= !age[31] && (age > {16'd0, strike_hold});
					young_q[idx_q] <= age[31] || (age < {16'd0, strike_hold});
					if (idx_q == LAST_IX) begin
						idx_q <= '0;
						st_q  <= ST_SCAN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_SCAN: begin
					if (go) begin
						if (gen) begin
							note_q[idx_q] <= 3'd0;
							snd_q[idx_q]  <= 1'b0;
							cnt_q         <= cnt_q + 3'd1;
						end
						if (idx_q == LAST_IX) st_q <= ST_FLUSH;
						else idx_q <= idx_q + 1'b1;
					end
				end
				ST_FLUSH: begin
					if (go) begin
						pend_q <= 1'b0;
						st_q   <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/cemnm_msg_unit.sv @@
// Back end: turns queued commands into MIDI words in an output register.
`timescale 1ns / 1ps
module cemnm_msg_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            empty,
	input  cemnm_pkg::cmd_t cmd,
	output logic            pop,
	input  logic [6:0]      base_note,
	input  logic [3:0]      drum_mode,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [23:0]     m_tdata,
	output logic            m_tlast
);
	logic        valid_q;
	logic [7:0]  status_q;
	logic [6:0]  pitch_q;
	logic        last_q;
	logic [4:0]  chan;
	logic [7:0]  status;

	assign pop    = !empty && (!valid_q || m_tready);
	assign chan   = cmd.mode - 5'd1;
	assign status = (cmd.on ? cemnm_pkg::STATUS_ON : cemnm_pkg::STATUS_OFF)
		| {4'd0, chan[3:0]};

	// Load the next word when the register is free or being taken
	always_ff @(posedge clk) begin
		if (pop) begin
			status_q <= status;
			pitch_q  <= cemnm_pkg::pitch_of(cmd.mode, cmd.note, base_note, drum_mode);
			last_q   <= cmd.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (pop) valid_q <= 1'b1;
		else if (m_tready) valid_q <= 1'b0;
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, cemnm_pkg::VELOCITY, pitch_q, status_q};
	assign m_tlast  = last_q;
endmodule

@@ hw/rtl/cube_event_midi_note_manager.sv @@
// A command is held in the front sequencer until the next command or the end of its item, then
// queued in the command FIFO and loaded into the output register of the message unit.
// The front sequencer takes a new item only when idle, once the previous one is done; a full
// queue stalls it. Words drain one per cycle while m_tready is high.
// Reset (arst_n low, asynchronous): all cubes silent with no note in mode 1, start times zero,
// registers back to strike limit 4, hold 100 ms, base note 69, drum mode 3.
`timescale 1ns / 1ps
`include "cube_event_midi_note_manager_macros.svh"
module cube_event_midi_note_manager #(
	parameter int CUBES = 6,
	parameter int MODES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // note_code[2:0], voice_mode[6:3], cube_id[9:7], now_ms[41:10]
	input  logic        s_tuser,   // mode (0 cube event, 1 time check)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status_byte[7:0], pitch[14:8], velocity[21:15]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);
	logic [3:0]  strike_limit_q;
	logic [15:0] strike_hold_q;
	logic [6:0]  base_note_q;
	logic [3:0]  drum_mode_q;

	logic                   push;
	cemnm_pkg::cmd_t        push_cmd;
	logic                   full;
	logic                   pop;
	logic                   empty;
	cemnm_pkg::cmd_t        pop_cmd;
	cemnm_pkg::front_stat_t front_stat;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strike_limit_q <= 4'd4;
			strike_hold_q  <= 16'd100;
			base_note_q    <= 7'd69;
			drum_mode_q    <= 4'd3;
		end else if (cfg_we) begin
			case (cfg_index)
				cemnm_pkg::REG_STRIKE_LIMIT: strike_limit_q <= cfg_wdata[3:0];
				cemnm_pkg::REG_STRIKE_HOLD:  strike_hold_q  <= cfg_wdata;
				cemnm_pkg::REG_BASE_NOTE:    base_note_q    <= cfg_wdata[6:0];
				cemnm_pkg::REG_DRUM_MODE:    drum_mode_q    <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	cemnm_front #(
		.CUBES (CUBES),
		.MODES (MODES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.strike_limit (strike_limit_q),
		.strike_hold  (strike_hold_q),
		.push         (push),
		.push_cmd     (push_cmd),
		.full         (full),
		.stat         (front_stat)
	);

	cemnm_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.pop_cmd  (pop_cmd)
	);

	cemnm_msg_unit u_msg (
		.clk       (clk),
		.arst_n    (arst_n),
		.empty     (empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.base_note (base_note_q),
		.drum_mode (drum_mode_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// The front never pushes into a full queue
	`CEMNM_ASSERT_NOW(a_no_overflow, push, !full, "command pushed into full queue")
	// A new item starts with no command left over from the previous one
	`CEMNM_ASSERT_NOW(a_clean_start, s_tvalid && s_tready, !front_stat.pend,
		"item accepted with a pending command")
	// Items are taken only while the front is idle
	`CEMNM_ASSERT_NOW(a_idle_accept, s_tvalid && s_tready, front_stat.idle,
		"item accepted while the front is busy")
	// The front is busy on the cycle after it takes an item
	`CEMNM_ASSERT_NEXT(a_busy_after, s_tvalid && s_tready, !s_tready,
		"front ready right after accepting an item")
	// Every word is a note on or a note off
	`CEMNM_ASSERT_NOW(a_status_kind, m_tvalid,
		m_tdata[7:4] == 4'h8 || m_tdata[7:4] == 4'h9, "bad status byte")
endmodule
